>>> rtl/alpd_pkg.sv
// shared types and constants for the ascii length-prefixed deframer
// used by alpd_parser and ascii_length_prefix_deframer_core; no dependencies
package alpd_pkg;

  localparam int MAX_BODY_DEF = 65535;
  localparam logic [4:0] MAX_HEADER = 5'd16;
  localparam logic [4:0] HDR_LEN_RESET = 5'd4;

  localparam int CFG_AW = 3;
  localparam logic REG_HEADER_LENGTH = 1'b0;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  typedef enum logic [1:0] {
    MODE_HEADER,
    MODE_BODY,
    MODE_DISCARD
  } mode_t;

  typedef enum logic [2:0] {
    PH_WS,
    PH_SIGN,
    PH_DIGITS,
    PH_DONE,
    PH_FAIL
  } phase_t;

  typedef enum logic [1:0] {
    KIND_BODY,
    KIND_EMPTY,
    KIND_ERROR
  } kind_t;

  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] body_byte;
    logic       last;
  } result_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

>>> rtl/alpd_parser.sv
// frame state and per-beat header parse / body count logic
// depends on alpd_pkg
module alpd_parser #(
  parameter int MAX_BODY = alpd_pkg::MAX_BODY_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        data_byte,
  input  logic              chunk_end,
  input  logic [4:0]        hdr_len,
  output alpd_pkg::result_t res
);

  localparam int AW = $clog2(MAX_BODY + 2);
  localparam int BW = $clog2(MAX_BODY + 1);
  localparam logic [AW-1:0] LIM = AW'(MAX_BODY + 1);
  localparam logic [AW-1:0] BODY_MAX = AW'(MAX_BODY);

  alpd_pkg::mode_t  mode_r, mode_nxt;
  alpd_pkg::phase_t phase_r, phase_nxt, phase_p;
  logic [4:0]       hidx_r, hidx_nxt, hidx_p;
  logic             minus_r, minus_nxt, minus_p;
  logic [AW-1:0]    acc_r, acc_nxt, acc_p, acc_dig;
  logic [BW-1:0]    left_r, left_nxt;
  logic [AW+3:0]    prod;
  logic             body_last, hdr_done, hdr_bad;

  // accumulate one decimal digit with saturation at max body plus one
  always_comb begin
    prod = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0}
         + {AW'(0), data_byte[3:0]};
    if (acc_r >= LIM || prod > {4'b0000, LIM}) begin
      acc_dig = LIM;
    end else begin
      acc_dig = prod[AW-1:0];
    end
  end

  // %d style parse of one header byte
  always_comb begin
    phase_p = phase_r;
    minus_p = minus_r;
    acc_p   = acc_r;
    case (phase_r)
      alpd_pkg::PH_WS: begin
        if (alpd_pkg::is_space(data_byte)) begin
          phase_p = alpd_pkg::PH_WS;
        end else if (data_byte == alpd_pkg::CH_PLUS || data_byte == alpd_pkg::CH_MINUS) begin
          minus_p = (data_byte == alpd_pkg::CH_MINUS);
          phase_p = alpd_pkg::PH_SIGN;
        end else if (alpd_pkg::is_digit(data_byte)) begin
          acc_p   = acc_dig;
          phase_p = alpd_pkg::PH_DIGITS;
        end else begin
          phase_p = alpd_pkg::PH_FAIL;
        end
      end
      alpd_pkg::PH_SIGN: begin
        if (alpd_pkg::is_digit(data_byte)) begin
          acc_p   = acc_dig;
          phase_p = alpd_pkg::PH_DIGITS;
        end else begin
          phase_p = alpd_pkg::PH_FAIL;
        end
      end
      alpd_pkg::PH_DIGITS: begin
        if (alpd_pkg::is_digit(data_byte)) begin
          acc_p = acc_dig;
        end else begin
          phase_p = alpd_pkg::PH_DONE;
        end
      end
      default: begin
        phase_p = phase_r;
      end
    endcase
    hidx_p    = hidx_r + 5'd1;
    hdr_done  = (hidx_p >= hdr_len);
    hdr_bad   = !(phase_p == alpd_pkg::PH_DIGITS || phase_p == alpd_pkg::PH_DONE)
              || (minus_p && acc_p != '0) || (acc_p > BODY_MAX);
    body_last = (left_r <= BW'(1));
  end

  // next state
  always_comb begin
    mode_nxt  = mode_r;
    phase_nxt = phase_r;
    hidx_nxt  = hidx_r;
    minus_nxt = minus_r;
    acc_nxt   = acc_r;
    left_nxt  = left_r;
    unique case (mode_r)
      alpd_pkg::MODE_DISCARD: begin
        if (chunk_end) begin
          mode_nxt = alpd_pkg::MODE_HEADER;
        end
      end
      alpd_pkg::MODE_BODY: begin
        if (body_last) begin
          left_nxt = '0;
          mode_nxt = alpd_pkg::MODE_HEADER;
        end else begin
          left_nxt = left_r - BW'(1);
        end
      end
      alpd_pkg::MODE_HEADER: begin
        if (!hdr_done) begin
          phase_nxt = phase_p;
          hidx_nxt  = hidx_p;
          minus_nxt = minus_p;
          acc_nxt   = acc_p;
        end else begin
          phase_nxt = alpd_pkg::PH_WS;
          hidx_nxt  = '0;
          minus_nxt = 1'b0;
          acc_nxt   = '0;
          if (hdr_bad) begin
            mode_nxt = chunk_end ? alpd_pkg::MODE_HEADER : alpd_pkg::MODE_DISCARD;
          end else if (acc_p == '0) begin
            mode_nxt = alpd_pkg::MODE_HEADER;
          end else begin
            left_nxt = acc_p[BW-1:0];
            mode_nxt = alpd_pkg::MODE_BODY;
          end
        end
      end
      default: begin
        mode_nxt = alpd_pkg::MODE_HEADER;
      end
    endcase
  end

  // result of this beat
  always_comb begin
    res = '0;
    unique case (mode_r)
      alpd_pkg::MODE_BODY: begin
        res.valid     = 1'b1;
        res.kind      = alpd_pkg::KIND_BODY;
        res.body_byte = data_byte;
        res.last      = body_last;
      end
      alpd_pkg::MODE_HEADER: begin
        if (hdr_done && hdr_bad) begin
          res.valid = 1'b1;
          res.kind  = alpd_pkg::KIND_ERROR;
        end else if (hdr_done && acc_p == '0) begin
          res.valid = 1'b1;
          res.kind  = alpd_pkg::KIND_EMPTY;
        end
      end
      default: begin
        res.valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= alpd_pkg::MODE_HEADER;
      phase_r <= alpd_pkg::PH_WS;
      hidx_r  <= '0;
      minus_r <= 1'b0;
      acc_r   <= '0;
      left_r  <= '0;
    end else if (step) begin
      mode_r  <= mode_nxt;
      phase_r <= phase_nxt;
      hidx_r  <= hidx_nxt;
      minus_r <= minus_nxt;
      acc_r   <= acc_nxt;
      left_r  <= left_nxt;
    end
  end

endmodule

>>> rtl/ascii_length_prefix_deframer_core.sv
// top level of the ascii length-prefixed deframer: stream ports, apb register,
// input and result registers; depends on alpd_pkg and alpd_parser
//
// channel   ports                         beat
// in        in_tvalid/in_tready            tdata: data_byte[7:0]; tlast: chunk_end
// out       out_tvalid/out_tready          tdata: body_byte[7:0]; tuser: kind; tlast: last
// cfg       cfg_psel/penable/pwrite/...    header_length at byte address 0
//
// one byte per cycle while out_tready is high; an accepted byte passes through the input register,
// then parse and the result register
// only the final header byte can give a beat (empty or error); discarded bytes give none
// synchronous active-low reset clears control state and header_length to 4
// out_tready low holds the result register and backs up into the input register
module ascii_length_prefix_deframer_core #(
  parameter int MAX_BODY = alpd_pkg::MAX_BODY_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // data_byte
  input  logic                        in_tlast,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [7:0]                  out_tdata,  // body_byte
  output logic [1:0]                  out_tuser,  // kind
  output logic                        out_tlast,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [alpd_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  logic [4:0]        hl_r;
  logic [4:0]        hdr_len;
  logic              s1_valid_r;
  logic [7:0]        s1_byte_r;
  logic              s1_end_r;
  logic              out_free, s1_go, in_acc, cfg_wr;
  logic              out_valid_r;
  logic [7:0]        out_byte_r;
  logic [1:0]        out_kind_r;
  logic              out_last_r;
  alpd_pkg::result_t res;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                    && (cfg_paddr[2] == alpd_pkg::REG_HEADER_LENGTH);
  assign cfg_prdata = (cfg_paddr[2] == alpd_pkg::REG_HEADER_LENGTH) ? {27'd0, hl_r} : 32'd0;

  always_comb begin
    if (hl_r == 5'd0) begin
      hdr_len = 5'd1;
    end else if (hl_r > alpd_pkg::MAX_HEADER) begin
      hdr_len = alpd_pkg::MAX_HEADER;
    end else begin
      hdr_len = hl_r;
    end
  end

  assign out_free  = !out_valid_r || out_tready;
  assign s1_go     = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || s1_go;
  assign in_acc    = in_tvalid && in_tready;

  alpd_parser #(
    .MAX_BODY(MAX_BODY)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_go),
    .data_byte (s1_byte_r),
    .chunk_end (s1_end_r),
    .hdr_len   (hdr_len),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hl_r        <= alpd_pkg::HDR_LEN_RESET;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        hl_r <= cfg_pwdata[4:0];
      end
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (out_free) begin
        out_valid_r <= s1_go && res.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_tdata;
      s1_end_r  <= in_tlast;
    end
    if (s1_go && res.valid) begin
      out_byte_r <= res.body_byte;
      out_kind_r <= res.kind;
      out_last_r <= res.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  a_marker_beats_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != alpd_pkg::KIND_BODY) |-> !out_tlast && (out_tdata == 8'd0))
    else $error("empty or error beat carries data or last");

  a_result_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(s1_go))
    else $error("result beat appeared without a parsed input byte");

  a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while result side is ready");

endmodule

>>> tb/sv/ascii_length_prefix_deframer_core_tb.sv
// self-checking testbench for ascii_length_prefix_deframer_core: directed and random
// length-prefixed frames checked beat by beat against a built-in deframer predictor
// depends on alpd_pkg and the rtl of the core
module ascii_length_prefix_deframer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BODY_LIMIT = alpd_pkg::MAX_BODY_DEF;
  localparam int ADDR_W = alpd_pkg::CFG_AW;
  localparam int QUIET_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 8;
  localparam int NUM_PHASES = 9;
  localparam int PHASE_BYTES = 140;
  localparam int LONG_BODY = 120;
  localparam int MAX_REPORTS = 10;
  localparam logic [ADDR_W-1:0] HDR_LEN_ADDR = ADDR_W'(4 * alpd_pkg::REG_HEADER_LENGTH);

  typedef struct packed {
    logic [7:0] data;
    logic       chunk_end;
  } stream_byte_t;

  typedef struct packed {
    alpd_pkg::kind_t kind;
    logic [7:0]      data;
    logic            last;
  } packet_beat_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata = '0;   // data_byte
  logic              in_tlast = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [7:0]        out_tdata;       // body_byte
  logic [1:0]        out_tuser;       // kind
  logic              out_tlast;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0]       cfg_pwdata = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  ascii_length_prefix_deframer_core dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // deframer state mirrored by the predictor
  alpd_pkg::mode_t  frame_mode = alpd_pkg::MODE_HEADER;
  alpd_pkg::phase_t parse_phase = alpd_pkg::PH_WS;
  logic [4:0]       hdr_index = '0;
  logic             minus_seen = 1'b0;
  int unsigned      len_acc = 0;
  int unsigned      body_left = 0;
  logic [4:0]       hdr_len_cfg = alpd_pkg::HDR_LEN_RESET;

  stream_byte_t pending_bytes[$];
  packet_beat_t expected_beats[$];
  logic [7:0]   hdr_text[$];
  int unsigned  bytes_unaccepted = 0;
  int unsigned  queued_bytes = 0;
  int           mismatches = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  int           quiet_cycles = 0;

  function automatic logic chance(input int pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic logic dec_char(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic blank_char(input logic [7:0] c);
    return c == 8'h20 || (c > 8'h08 && c < 8'h0E);
  endfunction

  function automatic logic [4:0] eff_hdr_len(input logic [4:0] v);
    if (v == 5'd0) return 5'd1;
    if (v > alpd_pkg::MAX_HEADER) return alpd_pkg::MAX_HEADER;
    return v;
  endfunction

  function automatic void push_digit(input logic [7:0] c);
    int unsigned nxt;
    nxt = len_acc * 10 + (c - 8'h30);
    if (len_acc > BODY_LIMIT || nxt > BODY_LIMIT + 1) nxt = BODY_LIMIT + 1;
    len_acc = nxt;
  endfunction

  function automatic void deframe_byte(input logic [7:0] c, input logic chunk_end);
    packet_beat_t beat;
    logic bad;
    beat = '{kind: alpd_pkg::KIND_BODY, data: c, last: 1'b0};
    case (frame_mode)
      alpd_pkg::MODE_DISCARD: begin
        if (chunk_end) frame_mode = alpd_pkg::MODE_HEADER;
      end
      alpd_pkg::MODE_BODY: begin
        beat.last = body_left <= 1;
        expected_beats.push_back(beat);
        if (beat.last) begin
          body_left = 0;
          frame_mode = alpd_pkg::MODE_HEADER;
        end else begin
          body_left--;
        end
      end
      default: begin
        case (parse_phase)
          alpd_pkg::PH_WS: begin
            if (blank_char(c)) begin
            end else if (c == alpd_pkg::CH_PLUS || c == alpd_pkg::CH_MINUS) begin
              minus_seen = c == alpd_pkg::CH_MINUS;
              parse_phase = alpd_pkg::PH_SIGN;
            end else if (dec_char(c)) begin
              push_digit(c);
              parse_phase = alpd_pkg::PH_DIGITS;
            end else begin
              parse_phase = alpd_pkg::PH_FAIL;
            end
          end
          alpd_pkg::PH_SIGN: begin
            if (dec_char(c)) begin
              push_digit(c);
              parse_phase = alpd_pkg::PH_DIGITS;
            end else begin
              parse_phase = alpd_pkg::PH_FAIL;
            end
          end
          alpd_pkg::PH_DIGITS: begin
            if (dec_char(c)) push_digit(c);
            else parse_phase = alpd_pkg::PH_DONE;
          end
          default: begin
          end
        endcase
        hdr_index = hdr_index + 5'd1;
        if (hdr_index >= eff_hdr_len(hdr_len_cfg)) begin
          bad = !(parse_phase == alpd_pkg::PH_DIGITS || parse_phase == alpd_pkg::PH_DONE) ||
                (minus_seen && len_acc != 0) || len_acc > BODY_LIMIT;
          beat.data = '0;
          if (bad) begin
            beat.kind = alpd_pkg::KIND_ERROR;
            expected_beats.push_back(beat);
            frame_mode = chunk_end ? alpd_pkg::MODE_HEADER : alpd_pkg::MODE_DISCARD;
          end else if (len_acc == 0) begin
            beat.kind = alpd_pkg::KIND_EMPTY;
            expected_beats.push_back(beat);
            frame_mode = alpd_pkg::MODE_HEADER;
          end else begin
            body_left = len_acc;
            frame_mode = alpd_pkg::MODE_BODY;
          end
          hdr_index = '0;
          parse_phase = alpd_pkg::PH_WS;
          minus_seen = 1'b0;
          len_acc = 0;
        end
      end
    endcase
  endfunction

  always @(posedge clk) begin : driver
    stream_byte_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        deframe_byte(in_tdata, in_tlast);
        bytes_unaccepted--;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_bytes.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= nxt.data;
          in_tlast <= nxt.chunk_end;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(input string what, input packet_beat_t exp_beat);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t %s: expected kind %0d byte %02h last %0b, got kind %0d byte %02h last %0b",
               $time, what, exp_beat.kind, exp_beat.data, exp_beat.last,
               out_tuser, out_tdata, out_tlast);
  endtask

  always @(posedge clk) begin : monitor
    packet_beat_t exp_beat;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= $urandom_range(99) >= recv_idle_pct;
      if (out_tvalid && out_tready) begin
        if (expected_beats.size() == 0) begin
          exp_beat = '0;
          report_mismatch("beat with none expected", exp_beat);
        end else begin
          exp_beat = expected_beats.pop_front();
          if (out_tuser !== exp_beat.kind || out_tdata !== exp_beat.data ||
              out_tlast !== exp_beat.last)
            report_mismatch("beat mismatch", exp_beat);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("ascii_length_prefix_deframer_core_tb: FAIL");
        $finish;
      end
    end
  end

  task automatic queue_byte(input logic [7:0] b, input logic e);
    stream_byte_t s;
    s.data = b;
    s.chunk_end = e;
    pending_bytes.push_back(s);
    bytes_unaccepted++;
    queued_bytes++;
  endtask

  function automatic logic [7:0] rand_blank();
    return chance(35) ? alpd_pkg::CH_SPACE : 8'(8'h09 + $urandom_range(4));
  endfunction

  function automatic logic [7:0] rand_non_digit();
    logic [7:0] c;
    if (chance(25)) return 8'h00;
    do c = 8'($urandom); while (dec_char(c));
    return c;
  endfunction

  function automatic logic [7:0] rand_bad_lead();
    logic [7:0] c;
    if (chance(25)) return 8'h00;
    do c = 8'($urandom);
    while (dec_char(c) || blank_char(c) || c == alpd_pkg::CH_PLUS || c == alpd_pkg::CH_MINUS);
    return c;
  endfunction

  task automatic append_text(input string s);
    for (int i = 0; i < s.len(); i++) hdr_text.push_back(s[i]);
  endtask

  // header bytes from hdr_text, then a non-digit stop, then filler
  task automatic queue_header(input int hlen, input logic end_last);
    logic [7:0] c;
    for (int i = 0; i < hlen; i++) begin
      if (i < hdr_text.size()) c = hdr_text[i];
      else if (i == hdr_text.size()) c = rand_non_digit();
      else c = 8'($urandom);
      queue_byte(c, (i == hlen - 1) ? end_last : chance(5));
    end
  endtask

  task automatic queue_good_frame(input int hlen);
    int unsigned len;
    int r;
    string digits;
    hdr_text.delete();
    r = $urandom_range(99);
    if (r < 15) len = 0;
    else if (r < 85 || hlen < 2) len = $urandom_range(1, 9);
    else len = $urandom_range(10, 60);
    digits = $sformatf("%0d", len);
    if (hlen > digits.len() && chance(25)) digits = {"0", digits};
    while (hdr_text.size() + digits.len() < hlen && chance(30))
      hdr_text.push_back(rand_blank());
    if (hdr_text.size() + digits.len() < hlen && chance(35))
      hdr_text.push_back((len == 0 && chance(50)) ? alpd_pkg::CH_MINUS : alpd_pkg::CH_PLUS);
    append_text(digits);
    if (len == 0) begin
      queue_header(hlen, chance(30));
    end else begin
      queue_header(hlen, chance(8));
      for (int i = 0; i < len; i++)
        queue_byte(8'($urandom), (i == len - 1) ? chance(30) : chance(8));
    end
  endtask

  task automatic queue_bad_frame(input int hlen);
    int sel;
    logic end_last;
    hdr_text.delete();
    sel = $urandom_range(2);
    if (sel == 0 && hlen >= 5) begin
      if (hlen >= 6 && chance(50))
        repeat ($urandom_range(6, hlen)) hdr_text.push_back(8'($urandom_range(8'h31, 8'h39)));
      else
        append_text($sformatf("%0d", $urandom_range(BODY_LIMIT + 1, 99999)));
    end else if (sel <= 1 && hlen >= 2) begin
      hdr_text.push_back(alpd_pkg::CH_MINUS);
      append_text($sformatf("%0d", $urandom_range(1, (hlen >= 4) ? 999 : 9)));
    end else if (chance(15)) begin
      repeat (hlen) hdr_text.push_back(rand_blank());
    end else begin
      while (hdr_text.size() < hlen - 2 && chance(30)) hdr_text.push_back(rand_blank());
      if (hdr_text.size() < hlen - 1 && chance(40)) begin
        hdr_text.push_back(chance(50) ? alpd_pkg::CH_PLUS : alpd_pkg::CH_MINUS);
        hdr_text.push_back(rand_non_digit());
      end else begin
        hdr_text.push_back(rand_bad_lead());
      end
    end
    end_last = chance(50);
    queue_header(hlen, end_last);
    if (!end_last) begin
      repeat ($urandom_range(4)) queue_byte(8'($urandom), 1'b0);
      queue_byte(8'($urandom), 1'b1);
    end
  endtask

  task automatic queue_frame(input int hlen);
    int r;
    r = $urandom_range(99);
    if (r < 72) begin
      queue_good_frame(hlen);
    end else if (r < 96) begin
      queue_bad_frame(hlen);
    end else begin
      repeat ($urandom_range(1, 3)) queue_byte(8'($urandom), chance(30));
    end
  endtask

  task automatic queue_long_frame(input int hlen);
    hdr_text.delete();
    append_text($sformatf("%0d", LONG_BODY));
    queue_header(hlen, 1'b0);
    for (int i = 0; i < LONG_BODY; i++) queue_byte(8'($urandom), i == LONG_BODY - 1);
  endtask

  task automatic drain_stream();
    while (bytes_unaccepted != 0 || expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_header_length(input logic [4:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= HDR_LEN_ADDR;
    cfg_pwdata <= 32'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    hdr_len_cfg = value;
  endtask

  initial begin : stimulus
    logic [4:0] hdr_settings[NUM_PHASES];
    logic [4:0] setting;
    int hlen;
    int unsigned phase_start;
    hdr_settings = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd9, 5'd2, 5'd16, 5'd3, 5'd4};
    send_idle_pct = 10;
    recv_idle_pct = 49;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset header length of four
    repeat (4) queue_byte(alpd_pkg::CH_ZERO, 1'b0);
    queue_byte(alpd_pkg::CH_MINUS, 1'b0);
    queue_byte(alpd_pkg::CH_ZERO, 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(alpd_pkg::CH_SPACE, 1'b0);
    queue_byte(alpd_pkg::CH_PLUS, 1'b0);
    queue_byte(8'h32, 1'b0);
    queue_byte(8'h78, 1'b0);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b0);
    queue_byte(alpd_pkg::CH_TAB, 1'b0);
    queue_byte(8'h0A, 1'b0);
    queue_byte(alpd_pkg::CH_MINUS, 1'b0);
    queue_byte(8'h31, 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h62, 1'b0);
    queue_byte(8'h63, 1'b0);
    queue_byte(8'h64, 1'b0);
    queue_byte(alpd_pkg::CH_NINE, 1'b0);
    queue_byte(alpd_pkg::CH_MINUS, 1'b1);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_stream();
      setting = (p == NUM_PHASES - 1) ? 5'($urandom_range(1, 16)) : hdr_settings[p];
      write_header_length(setting);
      hlen = eff_hdr_len(setting);
      if (p < 3) begin
        send_idle_pct = 10;
        recv_idle_pct = 49;
      end else if (p < 6) begin
        send_idle_pct = 49;
        recv_idle_pct = 10;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      phase_start = queued_bytes;
      if (p == 0) queue_long_frame(hlen);
      while (queued_bytes - phase_start < PHASE_BYTES) queue_frame(hlen);
    end

    drain_stream();
    if (mismatches == 0) begin
      $display("ascii_length_prefix_deframer_core_tb: PASS");
    end else begin
      $display("ascii_length_prefix_deframer_core_tb: FAIL");
    end
    $finish;
  end

endmodule
